// File: rtl/sbss_pkg.sv
`timescale 1ns / 1ps

package sbss_pkg;

	localparam int WL_W      = 32;
	localparam int IDX_W     = 9;
	localparam int CNT_W     = 10;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW     = 1'b0,
		REG_BAND_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_WRITTEN = 2'd0,
		ST_FOUND   = 2'd1,
		ST_NONE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		IX_ZERO,
		IX_ONE,
		IX_LAST,
		IX_LAST2,
		IX_I,
		IX_IM1,
		IX_IM2,
		IX_IP1
	} ix_sel_t;

	typedef struct packed {
		logic    take;
		logic    rd_en;
		logic    rd_b;
		logic    ld_a;
		logic    ld_b;
		logic    scan_clr;
		logic    scan_go;
		logic    res_load;
		status_t res_status;
		ix_sel_t sel_a;
		ix_sel_t sel_b;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_lt2;
		logic i_ge2;
		logic ip1_lt_n;
		logic hit;
		logic miss_end;
		logic outside;
		logic gap_ok;
		logic pair_ok;
		logic single_ok;
		logic slot_free;
	} sts_t;

endpackage

// File: rtl/sbss_dp.sv
`timescale 1ns / 1ps

module sbss_dp #(
	parameter int MAX_BANDS = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sbss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbss_pkg::WL_W-1:0]         cfg_data,
	input  logic                              in_valid,
	input  logic                              kind,
	input  logic [sbss_pkg::IDX_W-1:0]        entry_index,
	input  logic [sbss_pkg::WL_W-1:0]         wavelength,
	input  logic                              out_ready,
	input  sbss_pkg::cmd_t                    cmd,
	output sbss_pkg::sts_t                    sts,
	output logic                              out_valid,
	output logic [1:0]                        status,
	output logic [sbss_pkg::IDX_W-1:0]        left_index,
	output logic [sbss_pkg::IDX_W-1:0]        right_index
);
	import sbss_pkg::*;

	localparam int IW = $clog2(MAX_BANDS);
	localparam int NW = $clog2(MAX_BANDS + 1);
	localparam int CW = (NW > CNT_W) ? NW : CNT_W;

	logic [WL_W-1:0]   wl_table_q [MAX_BANDS];
	logic [WL_W-1:0]   rd_data_q;
	logic [IW-1:0]     rd_idx_q;
	logic              rd_vld_q;

	logic [WL_W-1:0]   win_q;
	logic [CNT_W-1:0]  bc_q;
	logic [WL_W-1:0]   w_q;
	logic [WL_W-1:0]   ta_q;
	logic [WL_W-1:0]   tb_q;
	logic signed [WL_W:0] d_ab_q;
	logic signed [WL_W:0] d_aw_q;
	logic signed [WL_W:0] d_wb_q;
	logic signed [WL_W:0] d_wa_q;
	logic [NW-1:0]     scan_q;
	logic [IW-1:0]     i_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [IDX_W-1:0]  left_q;
	logic [IDX_W-1:0]  right_q;

	logic [CW-1:0]     bc_ext;
	logic [NW-1:0]     n_eff;
	logic [NW-1:0]     nm1;
	logic [NW-1:0]     nm2;
	logic [NW-1:0]     i_ext;
	logic              acc;
	logic              wr_en;
	logic [CW-1:0]     wr_ext;
	logic [IW-1:0]     ix_a;
	logic [IW-1:0]     ix_b;
	logic [CW-1:0]     ix_a_ext;
	logic [CW-1:0]     ix_b_ext;
	logic              scan_rd;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;

	logic signed [WL_W:0] win_s;
	logic              aw_pos;
	logic              wb_pos;
	logic [WL_W+2:0]   m5_aw;
	logic [WL_W+2:0]   m5_wb;
	logic [WL_W-1:0]   abs_a;
	logic [WL_W+4:0]   m20;
	logic              gap_ok;
	logic              hit;

	function automatic logic [IW-1:0] ix_of(ix_sel_t sel, logic [IW-1:0] i,
			logic [IW-1:0] last, logic [IW-1:0] last2);
		logic [IW-1:0] r;
		unique case (sel)
			IX_ZERO:  r = '0;
			IX_ONE:   r = IW'(1);
			IX_LAST:  r = last;
			IX_LAST2: r = last2;
			IX_I:     r = i;
			IX_IM1:   r = i - IW'(1);
			IX_IM2:   r = i - IW'(2);
			IX_IP1:   r = i + IW'(1);
			default:  r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		bc_ext = CW'(bc_q);
		n_eff  = (bc_ext > CW'(MAX_BANDS)) ? NW'(MAX_BANDS) : bc_ext[NW-1:0];
		nm1    = n_eff - NW'(1);
		nm2    = n_eff - NW'(2);
		i_ext  = NW'(i_q);
	end

	assign acc    = in_valid && cmd.take;
	assign wr_ext = CW'(entry_index);
	assign wr_en  = acc && !kind && (wr_ext < CW'(MAX_BANDS));

	assign ix_a     = ix_of(cmd.sel_a, i_q, nm1[IW-1:0], nm2[IW-1:0]);
	assign ix_b     = ix_of(cmd.sel_b, i_q, nm1[IW-1:0], nm2[IW-1:0]);
	assign ix_a_ext = CW'(ix_a);
	assign ix_b_ext = CW'(ix_b);

	assign scan_rd = cmd.scan_go && (scan_q < n_eff);
	assign rd_en   = cmd.rd_en || scan_rd;
	assign rd_addr = scan_rd ? scan_q[IW-1:0] : (cmd.rd_b ? ix_b : ix_a);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wl_table_q[wr_ext[IW-1:0]] <= wavelength;
		end
		if (rd_en) begin
			rd_data_q <= wl_table_q[rd_addr];
			rd_idx_q  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			bc_q        <= CNT_W'(1);
			scan_q      <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_WINDOW:     win_q <= cfg_data;
					REG_BAND_COUNT: bc_q  <= cfg_data[CNT_W-1:0];
				endcase
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (scan_rd) begin
				scan_q <= scan_q + NW'(1);
			end
			rd_vld_q <= rd_en;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			w_q <= wavelength;
		end
		if (cmd.ld_a) begin
			ta_q <= rd_data_q;
		end
		if (cmd.ld_b) begin
			tb_q <= rd_data_q;
		end
		if (cmd.scan_go && hit) begin
			i_q <= rd_idx_q;
		end
		d_ab_q <= $signed({1'b0, tb_q}) - $signed({1'b0, ta_q});
		d_aw_q <= $signed({1'b0, ta_q}) - $signed({1'b0, w_q});
		d_wb_q <= $signed({1'b0, w_q}) - $signed({1'b0, tb_q});
		d_wa_q <= $signed({1'b0, w_q}) - $signed({1'b0, ta_q});
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			if (cmd.res_status == ST_FOUND) begin
				left_q  <= ix_a_ext[IDX_W-1:0];
				right_q <= ix_b_ext[IDX_W-1:0];
			end else begin
				left_q  <= '0;
				right_q <= '0;
			end
		end
	end

	always_comb begin
		win_s  = $signed({1'b0, win_q});
		aw_pos = !d_aw_q[WL_W] && (d_aw_q != '0);
		wb_pos = !d_wb_q[WL_W] && (d_wb_q != '0);
		m5_aw  = {1'b0, d_aw_q[WL_W-1:0], 2'b00} + {3'b000, d_aw_q[WL_W-1:0]};
		m5_wb  = {1'b0, d_wb_q[WL_W-1:0], 2'b00} + {3'b000, d_wb_q[WL_W-1:0]};
		abs_a  = d_aw_q[WL_W] ? d_wa_q[WL_W-1:0] : d_aw_q[WL_W-1:0];
		m20    = {1'b0, abs_a, 4'b0000} + {3'b000, abs_a, 2'b00};
		gap_ok = d_ab_q < win_s;
		hit    = rd_vld_q && (rd_data_q > w_q);
	end

	always_comb begin
		sts.n_zero    = (n_eff == '0);
		sts.n_lt2     = (n_eff < NW'(2));
		sts.i_ge2     = (i_ext >= NW'(2));
		sts.ip1_lt_n  = ((i_ext + NW'(1)) < n_eff);
		sts.hit       = hit;
		sts.miss_end  = rd_vld_q && !hit && (rd_idx_q == nm1[IW-1:0]);
		sts.outside   = aw_pos || wb_pos;
		sts.gap_ok    = gap_ok;
		sts.pair_ok   = gap_ok && ((aw_pos && (m5_aw < {3'b000, win_q}))
			|| (wb_pos && (m5_wb < {3'b000, win_q})));
		sts.single_ok = (m20 < {5'b00000, win_q});
		sts.slot_free = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign left_index  = left_q;
	assign right_index = right_q;

endmodule

// File: rtl/sbss_ctrl.sv
`timescale 1ns / 1ps

module sbss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           kind,
	input  sbss_pkg::sts_t sts,
	output logic           in_ready,
	output sbss_pkg::cmd_t cmd
);
	import sbss_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		RD_A,
		RD_B,
		LD_B,
		DIFF,
		EVAL,
		SCAN,
		FIN
	} state_t;

	typedef enum logic [3:0] {
		CK_RANGE,
		CK_END01,
		CK_ENDN,
		CK_GAP,
		CK_PREV,
		CK_NEXT,
		CK_SI,
		CK_SIM1,
		CK_SLAST
	} step_t;

	state_t  state_q;
	step_t   step_q;
	status_t fin_q;
	ix_sel_t sel_a;
	ix_sel_t sel_b;

	always_comb begin
		unique case (step_q)
			CK_RANGE: begin sel_a = IX_ZERO;  sel_b = IX_LAST; end
			CK_END01: begin sel_a = IX_ZERO;  sel_b = IX_ONE;  end
			CK_ENDN:  begin sel_a = IX_LAST2; sel_b = IX_LAST; end
			CK_GAP:   begin sel_a = IX_IM1;   sel_b = IX_I;    end
			CK_PREV:  begin sel_a = IX_IM2;   sel_b = IX_IM1;  end
			CK_NEXT:  begin sel_a = IX_I;     sel_b = IX_IP1;  end
			CK_SI:    begin sel_a = IX_I;     sel_b = IX_I;    end
			CK_SIM1:  begin sel_a = IX_IM1;   sel_b = IX_IM1;  end
			CK_SLAST: begin sel_a = IX_LAST;  sel_b = IX_LAST; end
			default:  begin sel_a = IX_ZERO;  sel_b = IX_ZERO; end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.res_status = fin_q;
		cmd.sel_a      = sel_a;
		cmd.sel_b      = sel_b;
		unique case (state_q)
			IDLE: begin
				cmd.take     = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			RD_A: cmd.rd_en = 1'b1;
			RD_B: begin
				cmd.rd_en = 1'b1;
				cmd.rd_b  = 1'b1;
				cmd.ld_a  = 1'b1;
			end
			LD_B: cmd.ld_b = 1'b1;
			DIFF: ;
			EVAL: ;
			SCAN: cmd.scan_go = 1'b1;
			FIN:  cmd.res_load = sts.slot_free;
			default: ;
		endcase
	end

	assign in_ready = (state_q == IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= CK_RANGE;
			fin_q   <= ST_NONE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						if (!kind) begin
							fin_q   <= ST_WRITTEN;
							state_q <= FIN;
						end else if (sts.n_zero) begin
							fin_q   <= ST_NONE;
							state_q <= FIN;
						end else begin
							step_q  <= CK_RANGE;
							state_q <= RD_A;
						end
					end
				end
				RD_A: state_q <= RD_B;
				RD_B: state_q <= LD_B;
				LD_B: state_q <= DIFF;
				DIFF: state_q <= EVAL;
				EVAL: begin
					unique case (step_q)
						CK_RANGE: begin
							if (!sts.outside) begin
								state_q <= SCAN;
							end else if (sts.n_lt2) begin
								fin_q   <= ST_NONE;
								state_q <= FIN;
							end else begin
								step_q  <= CK_END01;
								state_q <= RD_A;
							end
						end
						CK_END01: begin
							if (sts.pair_ok) begin
								fin_q   <= ST_FOUND;
								state_q <= FIN;
							end else begin
								step_q  <= CK_ENDN;
								state_q <= RD_A;
							end
						end
						CK_GAP: begin
							if (sts.gap_ok) begin
								fin_q   <= ST_FOUND;
								state_q <= FIN;
							end else if (sts.i_ge2) begin
								step_q  <= CK_PREV;
								state_q <= RD_A;
							end else if (sts.ip1_lt_n) begin
								step_q  <= CK_NEXT;
								state_q <= RD_A;
							end else begin
								step_q  <= CK_SI;
								state_q <= RD_A;
							end
						end
						CK_PREV: begin
							if (sts.pair_ok) begin
								fin_q   <= ST_FOUND;
								state_q <= FIN;
							end else if (sts.ip1_lt_n) begin
								step_q  <= CK_NEXT;
								state_q <= RD_A;
							end else begin
								step_q  <= CK_SI;
								state_q <= RD_A;
							end
						end
						CK_NEXT: begin
							if (sts.pair_ok) begin
								fin_q   <= ST_FOUND;
								state_q <= FIN;
							end else begin
								step_q  <= CK_SI;
								state_q <= RD_A;
							end
						end
						CK_SI: begin
							if (sts.single_ok) begin
								fin_q   <= ST_FOUND;
								state_q <= FIN;
							end else begin
								step_q  <= CK_SIM1;
								state_q <= RD_A;
							end
						end
						CK_ENDN: begin
							fin_q   <= sts.pair_ok ? ST_FOUND : ST_NONE;
							state_q <= FIN;
						end
						CK_SIM1, CK_SLAST: begin
							fin_q   <= sts.single_ok ? ST_FOUND : ST_NONE;
							state_q <= FIN;
						end
						default: begin
							fin_q   <= ST_NONE;
							state_q <= FIN;
						end
					endcase
				end
				SCAN: begin
					if (sts.hit) begin
						step_q  <= CK_GAP;
						state_q <= RD_A;
					end else if (sts.miss_end) begin
						step_q  <= CK_SLAST;
						state_q <= RD_A;
					end
				end
				FIN: begin
					if (sts.slot_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: rtl/spectral_band_source_selector_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Fields
// in       in   in_valid / in_ready    kind, entry_index, wavelength
// out      out  out_valid / out_ready  status, left_index, right_index
// cfg      in   cfg_wr_en              cfg_index, cfg_data
//
// A table write goes to the finish state, which raises out_valid once the result
// slot is free and then returns to idle, where the next item is taken.
// A query runs each table check through RD_A, RD_B, LD_B, DIFF and EVAL and
// scans up to n bands, one entry per cycle, for the first above the wavelength
// (no scan when it lies outside the table), then ends in the finish state.
// Reset clears control and the window and sets the band count to one; the
// table is undefined until written.
// A stalled result holds the next item in a finish state until taken.

module spectral_band_source_selector_unit #(
	parameter int MAX_BANDS = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sbss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbss_pkg::WL_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [sbss_pkg::IDX_W-1:0]     entry_index,
	input  logic [sbss_pkg::WL_W-1:0]      wavelength,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [sbss_pkg::IDX_W-1:0]     left_index,
	output logic [sbss_pkg::IDX_W-1:0]     right_index
);
	import sbss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sbss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	sbss_dp #(
		.MAX_BANDS (MAX_BANDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.kind        (kind),
		.entry_index (entry_index),
		.wavelength  (wavelength),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.status      (status),
		.left_index  (left_index),
		.right_index (right_index)
	);

endmodule

// File: rtl/sbss_checker.sv
`timescale 1ns / 1ps

module sbss_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       kind,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 status,
	input logic [sbss_pkg::IDX_W-1:0] left_index,
	input logic [sbss_pkg::IDX_W-1:0] right_index
);
	import sbss_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(left_index) && $stable(right_index))
		else $error("result changed while stalled");

	a_zero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> left_index == '0 && right_index == '0)
		else $error("nonzero index without a source");

	a_pair_adj: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FOUND |->
			right_index == left_index
			|| right_index == left_index + IDX_W'(1))
		else $error("source pair not adjacent");

	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind && !out_valid |->
			##2 out_valid && status == ST_WRITTEN)
		else $error("table write not acknowledged");

endmodule

bind spectral_band_source_selector_unit sbss_checker u_sbss_checker (.*);
